/* rtl/frustum_box_sphere_cull_defines.svh */
// Assertion macros for the frustum culling RTL.
// Included by frustum_box_sphere_cull, which checks its own pipeline control.
`ifndef FRUSTUM_BOX_SPHERE_CULL_DEFINES_SVH
`define FRUSTUM_BOX_SPHERE_CULL_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define FBSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbsc assertion failed");
// Next-cycle implication, disabled during reset.
`define FBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbsc assertion failed");
`else
`define FBSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/fbsc_pkg.sv */
// Shared types and constants for the frustum box/sphere culling block.
// No dependencies; used by fbsc_plane_unit and frustum_box_sphere_cull.
`default_nettype none

package fbsc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_W     = 64;
    localparam int FIELD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 2 * FIELD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int THR_W       = FIELD_W + 2;

    typedef enum logic {
        OP_BOX    = 1'b0,
        OP_SPHERE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_TOP    = 3'd0,
        CFG_PLANE_RIGHT  = 3'd1,
        CFG_PLANE_BOTTOM = 3'd2,
        CFG_PLANE_LEFT   = 3'd3,
        CFG_PLANE_NEAR   = 3'd4,
        CFG_PLANE_FAR    = 3'd5
    } t_cfg_idx;

    typedef logic signed [FIELD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec3;

    // Load enables for the pipeline stages held inside the plane units.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_adv;

endpackage

`default_nettype wire

/* rtl/fbsc_plane_unit.sv */
// One plane's datapath: products, per-axis minimum and sum, threshold compare.
// Depends on fbsc_pkg; stage load enables come from the top level.
`default_nettype none

module fbsc_plane_unit #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  fbsc_pkg::t_pipe_adv                 i_adv,
    input  logic [fbsc_pkg::PLANE_W-1:0]        i_plane,
    input  fbsc_pkg::t_op                       i_op,
    input  fbsc_pkg::t_vec3                     i_a,
    input  fbsc_pkg::t_vec3                     i_b,
    input  logic [fbsc_pkg::RADIUS_W-1:0]       i_radius,
    output logic                                o_outside
);
    import fbsc_pkg::*;

    localparam int SHIFT_W = THR_W + NORMAL_FRAC_BITS;
    localparam int CMP_W   = (SUM_W > SHIFT_W) ? SUM_W : SHIFT_W;

    t_coord w_nx;
    t_coord w_ny;
    t_coord w_nz;
    t_coord w_d;
    logic signed [THR_W-1:0]  n_thr;

    t_op                      r_s2_op;
    logic signed [PROD_W-1:0] r_s2_pa [3];
    logic signed [PROD_W-1:0] r_s2_pb [3];
    logic signed [THR_W-1:0]  r_s2_thr;

    logic signed [PROD_W-1:0] w_term [3];
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  r_s3_sum;
    logic signed [THR_W-1:0]  r_s3_thr;

    logic signed [CMP_W-1:0]  w_lhs;
    logic signed [CMP_W-1:0]  w_rhs;
    logic                     r_s4_out;

    assign w_nx = t_coord'(i_plane[63:48]);
    assign w_ny = t_coord'(i_plane[47:32]);
    assign w_nz = t_coord'(i_plane[31:16]);
    assign w_d  = t_coord'(i_plane[15:0]);

    // Both tests compare the dot product against (r - d) scaled to the normal's
    // fraction; the box test uses a zero radius.
    always_comb begin
        if (i_op == OP_SPHERE) begin
            n_thr = signed'(THR_W'(i_radius)) - THR_W'(w_d);
        end else begin
            n_thr = -THR_W'(w_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_s2_op    <= i_op;
            r_s2_pa[0] <= w_nx * i_a.x;
            r_s2_pa[1] <= w_ny * i_a.y;
            r_s2_pa[2] <= w_nz * i_a.z;
            r_s2_pb[0] <= w_nx * i_b.x;
            r_s2_pb[1] <= w_ny * i_b.y;
            r_s2_pb[2] <= w_nz * i_b.z;
            r_s2_thr   <= n_thr;
        end
    end

    // The box corner nearest the inside of the plane takes the smaller term
    // on every axis, whichever order the bounds came in.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_s2_op == OP_SPHERE || r_s2_pa[k] < r_s2_pb[k]) begin
                w_term[k] = r_s2_pa[k];
            end else begin
                w_term[k] = r_s2_pb[k];
            end
        end
        n_sum = SUM_W'(w_term[0]) + SUM_W'(w_term[1]) + SUM_W'(w_term[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_s3_sum <= n_sum;
            r_s3_thr <= r_s2_thr;
        end
    end

    assign w_lhs = CMP_W'(r_s3_sum);
    assign w_rhs = CMP_W'(signed'({r_s3_thr, {NORMAL_FRAC_BITS{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_s4_out <= (w_lhs > w_rhs);
        end
    end

    assign o_outside = r_s4_out;

endmodule

`default_nettype wire

/* rtl/frustum_box_sphere_cull.sv */
// Frustum culling of an axis-aligned box or a sphere against six planes.
// Depends on fbsc_pkg, fbsc_plane_unit and frustum_box_sphere_cull_defines.svh.
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_stall    i_operation, i_a_*, i_b_*, i_radius
//  out      from block o_out_valid / i_out_stall  o_culled
//  cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item enters per cycle unless o_in_stall holds it back; its result passes the
// input register, multiply, min and sum, and compare stages in that order.
// Six plane units work in parallel, one per plane, so rate does not depend on mode.
// Synchronous active-low reset clears all valid bits and the plane registers.
// A stall on the output fills empty stages first; the input stalls only when
// every stage holds an item.
`include "frustum_box_sphere_cull_defines.svh"
`default_nettype none

module frustum_box_sphere_cull #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic signed [fbsc_pkg::FIELD_W-1:0] i_a_x,
    input  logic signed [fbsc_pkg::FIELD_W-1:0] i_a_y,
    input  logic signed [fbsc_pkg::FIELD_W-1:0] i_a_z,
    input  logic signed [fbsc_pkg::FIELD_W-1:0] i_b_x,
    input  logic signed [fbsc_pkg::FIELD_W-1:0] i_b_y,
    input  logic signed [fbsc_pkg::FIELD_W-1:0] i_b_z,
    input  logic [fbsc_pkg::RADIUS_W-1:0]       i_radius,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_culled,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fbsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbsc_pkg::PLANE_W-1:0]        i_cfg_data
);
    import fbsc_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    logic [PLANE_W-1:0] r_plane [PLANE_COUNT];

    logic       r_s1_valid;
    logic       r_s2_valid;
    logic       r_s3_valid;
    logic       r_s4_valid;
    t_op        r_s1_op;
    t_vec3      r_s1_a;
    t_vec3      r_s1_b;
    logic [RADIUS_W-1:0] r_s1_radius;

    logic       w_rdy1;
    logic       w_rdy2;
    logic       w_rdy3;
    logic       w_rdy4;
    t_pipe_adv  w_adv;
    t_vec3      w_a;
    t_vec3      w_b;
    logic [PLANE_COUNT-1:0] w_outside;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_valid && i_cfg_index <= CFG_PLANE_FAR) begin
            r_plane[i_cfg_index] <= i_cfg_data;
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    assign w_rdy4 = !r_s4_valid || !i_out_stall;
    assign w_rdy3 = !r_s3_valid || w_rdy4;
    assign w_rdy2 = !r_s2_valid || w_rdy3;
    assign w_rdy1 = !r_s1_valid || w_rdy2;

    assign w_adv.s2 = w_rdy2;
    assign w_adv.s3 = w_rdy3;
    assign w_adv.s4 = w_rdy4;

    assign o_in_stall = !w_rdy1;

    // Coordinates count only in their low CW bits, sign-extended.
    assign w_a.x = t_coord'($signed(i_a_x[CW-1:0]));
    assign w_a.y = t_coord'($signed(i_a_y[CW-1:0]));
    assign w_a.z = t_coord'($signed(i_a_z[CW-1:0]));
    assign w_b.x = t_coord'($signed(i_b_x[CW-1:0]));
    assign w_b.y = t_coord'($signed(i_b_y[CW-1:0]));
    assign w_b.z = t_coord'($signed(i_b_z[CW-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_op     <= t_op'(i_operation);
            r_s1_a      <= w_a;
            r_s1_b      <= w_b;
            r_s1_radius <= i_radius;
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        fbsc_plane_unit #(
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_plane (
            .i_clk     (i_clk),
            .i_adv     (w_adv),
            .i_plane   (r_plane[g]),
            .i_op      (r_s1_op),
            .i_a       (r_s1_a),
            .i_b       (r_s1_b),
            .i_radius  (r_s1_radius),
            .o_outside (w_outside[g])
        );
    end

    assign o_out_valid = r_s4_valid;
    assign o_culled    = |w_outside;

    `FBSC_ASSERT_NOW(a_empty_no_stall, i_clk, i_rst_n, !r_s1_valid, !o_in_stall)
    `FBSC_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_s1_valid)
    `FBSC_ASSERT_NEXT(a_s2_moves_on, i_clk, i_rst_n, r_s2_valid && w_rdy3, r_s3_valid)
    `FBSC_ASSERT_NEXT(a_drain_empties_out, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !r_s3_valid, !o_out_valid)

endmodule

`default_nettype wire
